FILE: hdl/lpjc_pkg.sv
// Shared types and constants for the log-power to jet colour pipeline.
package lpjc_pkg;

  localparam int COMPONENT_WIDTH_DEF = 25;
  localparam int LOG_FRAC_BITS       = 12;
  localparam int LEVEL_W             = 11;
  localparam int BOUND_W             = 16;

  localparam logic [14:0] LOG10_OF_2_Q16 = 15'd19728;

  localparam logic [7:0] FLOOR_RESET   = 8'd112;
  localparam logic [7:0] CEILING_RESET = 8'd224;

  localparam logic [7:0] REG_FLOOR   = 8'd0;
  localparam logic [7:0] REG_CEILING = 8'd1;

  typedef struct packed {
    logic valid;
    logic zero;
  } tag_t;

endpackage

FILE: hdl/lpjc_log2.sv
// Pipelined fixed-point log2: leading-one encode, normalize, one squaring per stage.
module lpjc_log2 #(
  parameter int PW = 2 * lpjc_pkg::COMPONENT_WIDTH_DEF,
  parameter int LW = $clog2(PW) + lpjc_pkg::LOG_FRAC_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  lpjc_pkg::tag_t   tag_in,
  input  logic [PW-1:0]    power,
  output lpjc_pkg::tag_t   tag_out,
  output logic [LW-1:0]    log2_value
);
  import lpjc_pkg::*;

  localparam int EW = $clog2(PW);
  localparam int FB = LOG_FRAC_BITS;

  // leading-one encode stage
  tag_t          enc_tag;
  logic [PW-1:0] enc_power;
  logic [EW-1:0] enc_exp;
  logic [EW-1:0] enc_exp_next;

  // normalized mantissa stage (index 0) and squaring stages 1..FB
  tag_t          tag_q   [0:FB];
  logic [31:0]   m_q     [0:FB];
  logic [FB-1:0] frac_q  [0:FB];
  logic [EW-1:0] exp_q   [0:FB];

  logic [PW+30:0] norm_shift;
  logic [63:0]    sq_d     [1:FB];
  logic [32:0]    t_d      [1:FB];
  logic [31:0]    m_next   [1:FB];
  logic [FB-1:0]  frac_next[1:FB];

  always_comb begin
    enc_exp_next = '0;
    for (int i = 0; i < PW; i++) begin
      if (power[i]) begin
        enc_exp_next = EW'(i);
      end
    end
  end

  // put the top set bit at position 31
  assign norm_shift = {enc_power, 31'b0} >> enc_exp;

  always_comb begin
    for (int k = 1; k <= FB; k++) begin
      sq_d[k] = {32'b0, m_q[k-1]} * {32'b0, m_q[k-1]};
      t_d[k]  = sq_d[k][63:31];
      frac_next[k] = {frac_q[k-1][FB-2:0], t_d[k][32]};
      m_next[k] = t_d[k][32] ? t_d[k][32:1] : t_d[k][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enc_tag <= '0;
      for (int k = 0; k <= FB; k++) begin
        tag_q[k] <= '0;
      end
    end else if (advance) begin
      enc_tag  <= tag_in;
      tag_q[0] <= enc_tag;
      for (int k = 1; k <= FB; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      enc_power <= power;
      enc_exp   <= enc_exp_next;
      m_q[0]    <= norm_shift[31:0];
      frac_q[0] <= '0;
      exp_q[0]  <= enc_exp;
      for (int k = 1; k <= FB; k++) begin
        m_q[k]    <= m_next[k];
        frac_q[k] <= frac_next[k];
        exp_q[k]  <= exp_q[k-1];
      end
    end
  end

  assign tag_out    = tag_q[FB];
  assign log2_value = {exp_q[FB], frac_q[FB]};

endmodule

FILE: hdl/lpjc_div.sv
// Pipelined restoring divider giving the Q1.10 level, one quotient bit per stage.
module lpjc_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  lpjc_pkg::tag_t                    tag_in,
  input  logic [lpjc_pkg::BOUND_W-1:0]      numer,
  input  logic [lpjc_pkg::BOUND_W-1:0]      denom,
  output lpjc_pkg::tag_t                    tag_out,
  output logic [lpjc_pkg::LEVEL_W-1:0]      quotient
);
  import lpjc_pkg::*;

  localparam int QW = LEVEL_W;
  localparam int BW = BOUND_W;

  tag_t          tag_q  [0:QW-1];
  logic [BW-1:0] rem_q  [0:QW-1];
  logic [QW-1:0] quo_q  [0:QW-1];

  logic [BW:0]   r_d        [0:QW-1];
  logic          ge_d       [0:QW-1];
  logic [BW-1:0] rem_next   [0:QW-1];
  logic [QW-1:0] quo_next   [0:QW-1];

  // numerator never exceeds the divisor, so the first step yields the integer bit
  always_comb begin
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        r_d[k] = {1'b0, numer};
        quo_next[k] = '0;
      end else begin
        r_d[k] = {rem_q[k-1], 1'b0};
        quo_next[k] = {quo_q[k-1][QW-2:0], 1'b0};
      end
      ge_d[k] = r_d[k] >= {1'b0, denom};
      rem_next[k] = ge_d[k] ? BW'(r_d[k] - {1'b0, denom}) : r_d[k][BW-1:0];
      quo_next[k][0] = ge_d[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QW; k++) begin
        tag_q[k] <= '0;
      end
    end else if (advance) begin
      tag_q[0] <= tag_in;
      for (int k = 1; k < QW; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < QW; k++) begin
        rem_q[k] <= rem_next[k];
        quo_q[k] <= quo_next[k];
      end
    end
  end

  assign tag_out  = tag_q[QW-1];
  assign quotient = quo_q[QW-1];

endmodule

FILE: hdl/log_power_to_jet_color.sv
// Top level: complex bin to log power, normalized level and jet colour.
// Takes one complex spectrum bin per cycle while in_stall is low and returns one pixel per bin,
// in order, through 31 register stages, the first loaded by the transfer.
// Stages: magnitude, squares, power sum, a 14-stage log2 (encode, normalize, twelve squarings),
// log10 scaling, clamp, an 11-stage level divider and the colour/output register. Floor and
// ceiling are unsigned Q4.4 decades; write them only while no bin is in flight. A bin with zero
// power, or a ceiling not above the floor, gives level 0 (pure blue).
// in_stall rises only while a second pixel is parked behind an output held by out_stall; the
// whole pipeline then holds until the output drains.
module log_power_to_jet_color #(
  parameter int COMPONENT_WIDTH = lpjc_pkg::COMPONENT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [7:0]                   cfg_index,
  input  logic [7:0]                   cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [COMPONENT_WIDTH-1:0]   real_part,
  input  logic [COMPONENT_WIDTH-1:0]   imag_part,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   red,
  output logic [7:0]                   green,
  output logic [7:0]                   blue,
  output logic [lpjc_pkg::LEVEL_W-1:0] level
);
  import lpjc_pkg::*;

  localparam int CW    = COMPONENT_WIDTH;
  localparam int PW    = 2 * CW;
  localparam int LW    = $clog2(PW) + LOG_FRAC_BITS;
  localparam int DW    = LW - 1;
  localparam int CMP_W = (DW > BOUND_W) ? DW : BOUND_W;

  logic [7:0] floor_level;
  logic [7:0] ceiling_level;

  logic advance;
  logic skid_valid;

  tag_t          s1_tag, s2_tag, s3_tag, s4_tag, s5_tag;
  logic [CW-1:0] re_mag, im_mag;
  logic [PW-1:0] re_sq, im_sq;
  logic [PW-1:0] power;
  logic [DW-1:0] decades;
  logic [BOUND_W-1:0] numer;

  tag_t          log_tag;
  logic [LW-1:0] log2_value;
  tag_t          div_tag;
  logic [LEVEL_W-1:0] quotient;

  logic [LW+14:0]     log10_prod;
  logic [BOUND_W-1:0] lo_bound, hi_bound, denom;
  logic [CMP_W-1:0]   d_ext, lo_ext, hi_ext, d_clamp;

  logic [LEVEL_W-1:0] lvl;
  logic [7:0]         red_next, green_next, blue_next;
  logic               move;

  logic [7:0]         skid_red, skid_green, skid_blue;
  logic [LEVEL_W-1:0] skid_level;

  function automatic logic [7:0] scale255(input logic [8:0] x);
    logic [16:0] p;
    p = {x, 8'b0} - {8'b0, x};
    return p[15:8];
  endfunction

  assign advance  = !skid_valid;
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_level   <= FLOOR_RESET;
      ceiling_level <= CEILING_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FLOOR:   floor_level   <= cfg_data;
        REG_CEILING: ceiling_level <= cfg_data;
        default: ;
      endcase
    end
  end

  // bounds in Q.12 decades
  assign lo_bound = {floor_level, 8'b0};
  assign hi_bound = {ceiling_level, 8'b0};
  assign denom    = hi_bound - lo_bound;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag <= '0;
      s2_tag <= '0;
      s3_tag <= '0;
      s4_tag <= '0;
      s5_tag <= '0;
    end else if (advance) begin
      s1_tag <= '{valid: in_valid, zero: 1'b0};
      s2_tag <= s1_tag;
      s3_tag <= '{valid: s2_tag.valid,
                  zero: ((re_sq + im_sq) == '0) || (ceiling_level <= floor_level)};
      s4_tag <= log_tag;
      s5_tag <= s4_tag;
    end
  end

  assign log10_prod = (LW+15)'(log2_value) * (LW+15)'(LOG10_OF_2_Q16);
  assign d_ext  = CMP_W'(decades);
  assign lo_ext = CMP_W'(lo_bound);
  assign hi_ext = CMP_W'(hi_bound);

  always_comb begin
    if (d_ext < lo_ext) begin
      d_clamp = lo_ext;
    end else if (d_ext > hi_ext) begin
      d_clamp = hi_ext;
    end else begin
      d_clamp = d_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      re_mag  <= real_part[CW-1] ? (~real_part + 1'b1) : real_part;
      im_mag  <= imag_part[CW-1] ? (~imag_part + 1'b1) : imag_part;
      re_sq   <= PW'(re_mag) * PW'(re_mag);
      im_sq   <= PW'(im_mag) * PW'(im_mag);
      power   <= re_sq + im_sq;
      decades <= log10_prod[LW+14:16];
      numer   <= BOUND_W'(d_clamp - lo_ext);
    end
  end

  lpjc_log2 #(
    .PW (PW),
    .LW (LW)
  ) u_log2 (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .tag_in     (s3_tag),
    .power      (power),
    .tag_out    (log_tag),
    .log2_value (log2_value)
  );

  lpjc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .tag_in   (s5_tag),
    .numer    (numer),
    .denom    (denom),
    .tag_out  (div_tag),
    .quotient (quotient)
  );

  // jet colormap, three segments
  assign lvl = div_tag.zero ? '0 : quotient;

  always_comb begin
    if (lvl < 11'd512) begin
      red_next = '0;
    end else if (lvl > 11'd768) begin
      red_next = 8'hFF;
    end else begin
      red_next = scale255(9'(lvl - 11'd512));
    end

    if (lvl < 11'd256) begin
      green_next = scale255(9'(lvl));
    end else if (lvl > 11'd768) begin
      green_next = scale255(9'(11'd1024 - lvl));
    end else begin
      green_next = 8'hFF;
    end

    if (lvl < 11'd256) begin
      blue_next = 8'hFF;
    end else if (lvl > 11'd512) begin
      blue_next = '0;
    end else begin
      blue_next = scale255(9'(11'd512 - lvl));
    end
  end

  assign move = advance && div_tag.valid;

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= move;
      end
    end else if (move) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        red   <= skid_red;
        green <= skid_green;
        blue  <= skid_blue;
        level <= skid_level;
      end else if (move) begin
        red   <= red_next;
        green <= green_next;
        blue  <= blue_next;
        level <= lvl;
      end
    end else if (move) begin
      skid_red   <= red_next;
      skid_green <= green_next;
      skid_blue  <= blue_next;
      skid_level <= lvl;
    end
  end

  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid entry occupied without a held output");

  assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_stall |=> skid_valid)
    else $error("parked pixel dropped while output held");

  assert property (@(posedge clk) disable iff (rst) out_valid |-> level <= 11'd1024)
    else $error("level above full scale");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && level == '0 |-> red == 8'h00 && green == 8'h00 && blue == 8'hFF)
    else $error("zero level not mapped to pure blue");

endmodule

FILE: bench/tb_log_power_to_jet_color.sv
// Self-checking testbench for the log-power to jet colour pipeline.
`timescale 1ns / 1ps

module tb_log_power_to_jet_color;
  import lpjc_pkg::*;

  localparam int CW = COMPONENT_WIDTH_DEF;
  localparam int LVW = LEVEL_W;

  localparam longint unsigned LOG10_2_Q16 = 64'd19728;
  localparam logic [7:0] FLOOR_AT_RESET = 8'd112;
  localparam logic [7:0] CEIL_AT_RESET  = 8'd224;

  // indexes that map to no register
  localparam logic [7:0] REG_SPARE = 8'd2;
  localparam logic [7:0] REG_TOP   = 8'hFF;

  localparam logic [CW-1:0] C_MAXPOS = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] C_MINNEG = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] C_NEG1   = {CW{1'b1}};

  localparam int N_BLOCKS     = 9;
  localparam int BLOCK_BINS   = 60;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [7:0]     red;
    logic [7:0]     green;
    logic [7:0]     blue;
    logic [LVW-1:0] lvl;
  } pixel_t;

  typedef enum logic [0:0] {ROW_BIN, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t      kind;
    logic [7:0]     reg_index;
    logic [7:0]     reg_value;
    logic [CW-1:0]  re;
    logic [CW-1:0]  im;
    logic           typed;
    logic [7:0]     red;
    logic [7:0]     green;
    logic [7:0]     blue;
    logic [LVW-1:0] lvl;
  } stim_row_t;

  localparam int N_ROWS = 33;

  // typed rows carry the expected pixel; the rest go through the predictor
  localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
    '{ROW_BIN,   8'd0, 8'd0,   25'd0,      25'd0,      1'b1, 8'd0,   8'd0, 8'd255, 11'd0},
    '{ROW_BIN,   8'd0, 8'd0,   25'd1,      25'd0,      1'b1, 8'd0,   8'd0, 8'd255, 11'd0},
    '{ROW_BIN,   8'd0, 8'd0,   C_NEG1,     C_NEG1,     1'b1, 8'd0,   8'd0, 8'd255, 11'd0},
    '{ROW_BIN,   8'd0, 8'd0,   C_MAXPOS,   C_MAXPOS,   1'b1, 8'd255, 8'd0, 8'd0,   11'd1024},
    '{ROW_BIN,   8'd0, 8'd0,   C_MINNEG,   C_MINNEG,   1'b1, 8'd255, 8'd0, 8'd0,   11'd1024},
    '{ROW_BIN,   8'd0, 8'd0,   C_MINNEG,   25'd0,      1'b1, 8'd255, 8'd0, 8'd0,   11'd1024},
    '{ROW_BIN,   8'd0, 8'd0,   25'd0,      C_MAXPOS,   1'b1, 8'd255, 8'd0, 8'd0,   11'd1024},
    '{ROW_BIN,   8'd0, 8'd0,   25'd4000,   -25'sd3000, 1'b0, 8'd0,   8'd0, 8'd0,   11'd0},
    '{ROW_BIN,   8'd0, 8'd0,   25'd100000, 25'd0,      1'b0, 8'd0,   8'd0, 8'd0,   11'd0},
    '{ROW_BIN,   8'd0, 8'd0,   25'd0,   -25'sd2000000, 1'b0, 8'd0,   8'd0, 8'd0,   11'd0},
    '{ROW_BIN,   8'd0, 8'd0,   25'd5000000, 25'd5000000, 1'b0, 8'd0, 8'd0, 8'd0,   11'd0},
    '{ROW_BIN,   8'd0, 8'd0,   25'd31623,  25'd0,      1'b0, 8'd0,   8'd0, 8'd0,   11'd0},
    '{ROW_WRITE, REG_FLOOR,   8'd0,   25'd0, 25'd0,    1'b0, 8'd0,   8'd0, 8'd0,   11'd0},
    '{ROW_WRITE, REG_CEILING, 8'd255, 25'd0, 25'd0,    1'b0, 8'd0,   8'd0, 8'd0,   11'd0},
    '{ROW_BIN,   8'd0, 8'd0,   25'd1,      25'd0,      1'b1, 8'd0,   8'd0, 8'd255, 11'd0},
    '{ROW_BIN,   8'd0, 8'd0,   C_MAXPOS,   C_MINNEG,   1'b0, 8'd0,   8'd0, 8'd0,   11'd0},
    '{ROW_BIN,   8'd0, 8'd0,   25'd3,      -25'sd4,    1'b0, 8'd0,   8'd0, 8'd0,   11'd0},
    '{ROW_BIN,   8'd0, 8'd0,   25'd7,      25'd0,      1'b0, 8'd0,   8'd0, 8'd0,   11'd0},
    '{ROW_WRITE, REG_FLOOR,   8'd255, 25'd0, 25'd0,    1'b0, 8'd0,   8'd0, 8'd0,   11'd0},
    '{ROW_BIN,   8'd0, 8'd0,   C_MAXPOS,   25'd0,      1'b1, 8'd0,   8'd0, 8'd255, 11'd0},
    '{ROW_WRITE, REG_FLOOR,   8'd200, 25'd0, 25'd0,    1'b0, 8'd0,   8'd0, 8'd0,   11'd0},
    '{ROW_WRITE, REG_CEILING, 8'd100, 25'd0, 25'd0,    1'b0, 8'd0,   8'd0, 8'd0,   11'd0},
    '{ROW_BIN,   8'd0, 8'd0,   25'd12345,  -25'sd6789, 1'b1, 8'd0,   8'd0, 8'd255, 11'd0},
    '{ROW_BIN,   8'd0, 8'd0,   C_MINNEG,   C_MINNEG,   1'b1, 8'd0,   8'd0, 8'd255, 11'd0},
    '{ROW_WRITE, REG_FLOOR,   8'd0,   25'd0, 25'd0,    1'b0, 8'd0,   8'd0, 8'd0,   11'd0},
    '{ROW_WRITE, REG_CEILING, 8'd1,   25'd0, 25'd0,    1'b0, 8'd0,   8'd0, 8'd0,   11'd0},
    '{ROW_WRITE, REG_SPARE,   8'd200, 25'd0, 25'd0,    1'b0, 8'd0,   8'd0, 8'd0,   11'd0},
    '{ROW_WRITE, REG_TOP,     8'd0,   25'd0, 25'd0,    1'b0, 8'd0,   8'd0, 8'd0,   11'd0},
    '{ROW_BIN,   8'd0, 8'd0,   25'd1,      25'd1,      1'b0, 8'd0,   8'd0, 8'd0,   11'd0},
    '{ROW_BIN,   8'd0, 8'd0,   25'd1,      25'd0,      1'b1, 8'd0,   8'd0, 8'd255, 11'd0},
    '{ROW_WRITE, REG_FLOOR,   FLOOR_AT_RESET, 25'd0, 25'd0, 1'b0, 8'd0, 8'd0, 8'd0, 11'd0},
    '{ROW_WRITE, REG_CEILING, CEIL_AT_RESET,  25'd0, 25'd0, 1'b0, 8'd0, 8'd0, 8'd0, 11'd0},
    '{ROW_BIN,   8'd0, 8'd0,   25'd2000,   25'd1000,   1'b0, 8'd0,   8'd0, 8'd0,   11'd0}
  };

  logic           clk = 1'b0;
  logic           rst;
  logic           cfg_write;
  logic [7:0]     cfg_index;
  logic [7:0]     cfg_data;
  logic           in_valid;
  logic           in_stall;
  logic [CW-1:0]  real_part;
  logic [CW-1:0]  imag_part;
  logic           out_valid;
  logic           out_stall;
  logic [7:0]     red;
  logic [7:0]     green;
  logic [7:0]     blue;
  logic [LVW-1:0] level;

  log_power_to_jet_color #(
    .COMPONENT_WIDTH(CW)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .real_part (real_part),
    .imag_part (imag_part),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .level     (level)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the bound registers
  logic [7:0] floor_q44 = FLOOR_AT_RESET;
  logic [7:0] ceil_q44  = CEIL_AT_RESET;

  pixel_t pending_pixels [$];
  int     mismatches = 0;
  int     bins_sent = 0;
  int     pixels_seen = 0;
  int     reg_writes = 0;
  int     cycle_count = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  bit     hold_armed = 1'b0;

  function automatic logic [63:0] bin_magnitude(logic [CW-1:0] raw);
    longint x;
    x = $signed(raw);
    if (x < 0) x = -x;
    return x;
  endfunction

  // log2 in unsigned Q6.12 by normalize and repeated squaring
  function automatic logic [63:0] log2_q12(logic [63:0] p);
    int         e;
    logic [63:0] m;
    logic [63:0] frac;
    e = 0;
    frac = 0;
    for (int i = 0; i < 64; i++) if (p[i]) e = i;
    if (e > 31) m = p >> (e - 31);
    else m = p << (31 - e);
    for (int i = 0; i < 12; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac = frac | 64'd1;
        m = m >> 1;
      end
    end
    return (64'(e) << 12) | frac;
  endfunction

  function automatic pixel_t jet_pixel_of(logic [CW-1:0] re, logic [CW-1:0] im,
                                          logic [7:0] fl, logic [7:0] cl);
    logic [63:0] mr, mi, pw, d, lo, hi, lv;
    pixel_t      px;
    mr = bin_magnitude(re);
    mi = bin_magnitude(im);
    pw = mr * mr + mi * mi;
    lo = 64'(fl) << 8;
    hi = 64'(cl) << 8;
    lv = 0;
    if (cl > fl && pw != 0) begin
      d = (log2_q12(pw) * LOG10_2_Q16) >> 16;
      if (d < lo) d = lo;
      if (d > hi) d = hi;
      lv = ((d - lo) << 10) / (hi - lo);
    end
    if (lv < 512) px.red = 8'd0;
    else if (lv > 768) px.red = 8'd255;
    else px.red = 8'((64'd255 * (lv - 512)) >> 8);
    if (lv < 256) px.green = 8'((64'd255 * lv) >> 8);
    else if (lv > 768) px.green = 8'((64'd255 * (1024 - lv)) >> 8);
    else px.green = 8'd255;
    if (lv < 256) px.blue = 8'd255;
    else if (lv > 512) px.blue = 8'd0;
    else px.blue = 8'((64'd255 * (512 - lv)) >> 8);
    px.lvl = LVW'(lv);
    return px;
  endfunction

  // mostly spread over magnitudes so the log covers every decade
  function automatic logic [CW-1:0] random_component();
    int unsigned   pick;
    int unsigned   k;
    logic [31:0]   mask;
    logic [CW-1:0] v;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      v = CW'($urandom);
    end else if (pick == 2) begin
      case ($urandom_range(0, 4))
        0: v = '0;
        1: v = C_MAXPOS;
        2: v = C_MINNEG;
        3: v = C_NEG1;
        default: v = CW'(1);
      endcase
    end else begin
      k = $urandom_range(0, CW - 1);
      mask = (32'd1 << k) - 32'd1;
      v = CW'($urandom & mask);
      if ($urandom_range(0, 1) == 1) v = -v;
    end
    return v;
  endfunction

  task automatic drain_pixels();
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [7:0] val);
    in_valid <= 1'b0;
    drain_pixels();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_FLOOR) floor_q44 = val;
    else if (idx == REG_CEILING) ceil_q44 = val;
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic program_bounds(logic [7:0] fl, logic [7:0] cl);
    write_reg(REG_FLOOR, fl);
    write_reg(REG_CEILING, cl);
  endtask

  // offer one bin, hold it until transfer, then queue its pixel
  task automatic send_bin(logic [CW-1:0] re, logic [CW-1:0] im, logic typed, pixel_t given);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    real_part <= re;
    imag_part <= im;
    do @(posedge clk); while (in_stall);
    if (typed) pending_pixels.push_back(given);
    else pending_pixels.push_back(jet_pixel_of(re, im, floor_q44, ceil_q44));
    bins_sent++;
  endtask

  // output side: random stall, plus one long hold to back the pipeline up
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    pixel_t want;
    if (!rst && out_valid && !out_stall) begin
      pixels_seen++;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected pixel: rgb %0d %0d %0d level %0d", red, green, blue, level);
      end else begin
        want = pending_pixels.pop_front();
        if (red !== want.red || green !== want.green || blue !== want.blue ||
            level !== want.lvl) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("pixel %0d mismatch: exp rgb %0d %0d %0d level %0d, got %0d %0d %0d level %0d",
                     pixels_seen - 1, want.red, want.green, want.blue, want.lvl,
                     red, green, blue, level);
        end
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d pixels outstanding", cycle_count,
             pending_pixels.size());
    $display("[log_power_to_jet_color] ERROR");
    $finish;
  end

  initial begin
    stim_row_t row;
    pixel_t    given;
    logic [7:0] fl, cl;
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = 8'd0;
    cfg_data  = 8'd0;
    in_valid  = 1'b0;
    real_part = '0;
    imag_part = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, sender and receiver without idling
    for (int i = 0; i < N_ROWS; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_WRITE) begin
        write_reg(row.reg_index, row.reg_value);
      end else begin
        given = '{row.red, row.green, row.blue, row.lvl};
        send_bin(row.re, row.im, row.typed, given);
      end
    end

    for (int blk = 0; blk < N_BLOCKS; blk++) begin
      case (blk)
        0: ;
        2: program_bounds(8'd0, 8'd255);
        4: program_bounds(8'd255, 8'd0);
        7: begin
          fl = 8'($urandom_range(0, 254));
          program_bounds(fl, fl + 8'd1);
        end
        default: begin
          fl = 8'($urandom_range(0, 200));
          cl = 8'($urandom_range(fl + 1, 255));
          program_bounds(fl, cl);
        end
      endcase
      if (blk < 3) begin
        send_idle_pct = 27;
        recv_idle_pct <= 49;
      end else if (blk < 6) begin
        send_idle_pct = 49;
        recv_idle_pct <= 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      if (blk == 6) hold_armed <= 1'b1;
      for (int n = 0; n < BLOCK_BINS; n++)
        send_bin(random_component(), random_component(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    drain_pixels();
    repeat (TAIL_CYCLES) @(posedge clk);
    mismatches += pending_pixels.size();

    $display("sent %0d bins, checked %0d pixels, %0d register writes, %0d mismatches",
             bins_sent, pixels_seen, reg_writes, mismatches);
    $display("covered zero and saturated power, inverted and narrow bounds, a long output hold");
    if (mismatches == 0) begin
      $display("[log_power_to_jet_color] OK");
    end else begin
      $display("[log_power_to_jet_color] ERROR");
    end
    $finish;
  end

endmodule
